>>> src/fcpc_pkg.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter package
// Shared widths, register codes, reset values, types and the saturating
// increment used by the counters.
// ----------------------------------------------------------------------------
package fcpc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_PIXELS = 4194304;

  localparam logic [CNT_W-1:0] CNT_CAP =
      (MAX_PIXELS > ((2 ** CNT_W) - 1)) ? {CNT_W{1'b1}} : CNT_W'(MAX_PIXELS);

  localparam int unsigned PROD_W    = 17;
  localparam int unsigned PCT_SCALE = 100;

  localparam logic [PIX_W-1:0] PCT_RESET   = 8'd20;
  localparam logic [PIX_W-1:0] LEVEL_RESET = 8'd16;
  localparam logic [PIX_W-1:0] STEP_RESET  = 8'd8;
  localparam logic [CNT_W-1:0] AREA_RESET  = 23'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCT       = 2'd0,
    CFG_LOW_LEVEL = 2'd1,
    CFG_STEP      = 2'd2,
    CFG_AREA      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pct_threshold;
    logic [PIX_W-1:0] low_level;
    logic [PIX_W-1:0] low_step_limit;
    logic [CNT_W-1:0] area_limit;
  } cfg_t;

  typedef struct packed {
    logic hit_low;
    logic hit_high;
    logic last;
  } pix_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_CAP) ? CNT_CAP : v + CNT_W'(1);
  endfunction

endpackage

>>> src/fcpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter configuration registers
// Holds the four thresholds; writes to an unknown index are ignored.
// ----------------------------------------------------------------------------
module fcpc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcpc_pkg::CNT_W-1:0]     cfg_data_i,
  output fcpc_pkg::cfg_t                 cfg_o
);
  import fcpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PCT:       cfg_d.pct_threshold  = cfg_data_i[PIX_W-1:0];
        CFG_LOW_LEVEL: cfg_d.low_level      = cfg_data_i[PIX_W-1:0];
        CFG_STEP:      cfg_d.low_step_limit = cfg_data_i[PIX_W-1:0];
        CFG_AREA:      cfg_d.area_limit     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pct_threshold  <= PCT_RESET;
      cfg_q.low_level      <= LEVEL_RESET;
      cfg_q.low_step_limit <= STEP_RESET;
      cfg_q.area_limit     <= AREA_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/fcpc_classify.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter pair classifier
// Decides whether one registered pixel pair is a dark or a bright change.
// ----------------------------------------------------------------------------
module fcpc_classify (
  input  logic [fcpc_pkg::PIX_W-1:0] prev_pixel_i,
  input  logic [fcpc_pkg::PIX_W-1:0] curr_pixel_i,
  input  logic                       last_pixel_i,
  input  fcpc_pkg::cfg_t             cfg_i,
  output fcpc_pkg::pix_res_t         res_o
);
  import fcpc_pkg::*;

  logic [PROD_W-1:0] curr_scaled;
  logic [PROD_W-1:0] upper_bound;
  logic [PROD_W-1:0] lower_bound;
  logic              pct_small;
  logic              bright;
  logic              bright_up, bright_down;
  logic [PIX_W:0]    dark_upper;
  logic              dark_up, dark_down;

  always_comb begin
    curr_scaled = PROD_W'(curr_pixel_i) * PROD_W'(PCT_SCALE);
    upper_bound = PROD_W'(prev_pixel_i) *
                  (PROD_W'(PCT_SCALE) + PROD_W'(cfg_i.pct_threshold));
    pct_small   = cfg_i.pct_threshold <= PIX_W'(PCT_SCALE);
    lower_bound = PROD_W'(prev_pixel_i) *
                  (PROD_W'(PCT_SCALE) - PROD_W'(cfg_i.pct_threshold));
    bright_up   = curr_scaled > upper_bound;
    bright_down = pct_small && (curr_scaled < lower_bound);

    dark_upper  = {1'b0, prev_pixel_i} + {1'b0, cfg_i.low_step_limit};
    dark_up     = {1'b0, curr_pixel_i} > dark_upper;
    dark_down   = (prev_pixel_i >= cfg_i.low_step_limit) &&
                  (curr_pixel_i < (prev_pixel_i - cfg_i.low_step_limit));

    bright = (curr_pixel_i > cfg_i.low_level) || (prev_pixel_i > cfg_i.low_level);

    res_o.hit_high = bright && (bright_up || bright_down);
    res_o.hit_low  = !bright && (dark_up || dark_down);
    res_o.last     = last_pixel_i;
  end

endmodule

>>> src/fcpc_count.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter accumulator and report register
// Counts dark and bright changes and registers the frame report.
// ----------------------------------------------------------------------------
module fcpc_count (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  fcpc_pkg::pix_res_t         res_i,
  input  logic [fcpc_pkg::CNT_W-1:0] area_limit_i,
  output logic                       slot_free_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       over_limit_o,
  output logic [fcpc_pkg::CNT_W-1:0] changed_count_o,
  output logic [fcpc_pkg::CNT_W-1:0] low_changed_o,
  output logic [fcpc_pkg::CNT_W-1:0] high_changed_o
);
  import fcpc_pkg::*;

  logic [CNT_W-1:0] low_q, low_d, high_q, high_d;
  logic [CNT_W-1:0] low_inc, high_inc;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] total;
  logic             report;
  logic             out_valid_q, out_valid_d;
  logic             over_q;
  logic [CNT_W-1:0] total_q, low_out_q, high_out_q;

  always_comb begin
    low_inc  = res_i.hit_low  ? sat_inc(low_q)  : low_q;
    high_inc = res_i.hit_high ? sat_inc(high_q) : high_q;
    sum      = {1'b0, low_inc} + {1'b0, high_inc};
    total    = (sum > {1'b0, CNT_CAP}) ? CNT_CAP : sum[CNT_W-1:0];
    report   = adv_i && res_i.last;

    low_d  = low_q;
    high_d = high_q;
    if (adv_i) begin
      low_d  = res_i.last ? '0 : low_inc;
      high_d = res_i.last ? '0 : high_inc;
    end

    slot_free_o = !out_valid_q || !out_stall_i;
    out_valid_d = report || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      over_q     <= total > area_limit_i;
      total_q    <= total;
      low_out_q  <= low_inc;
      high_out_q <= high_inc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign over_limit_o    = over_q;
  assign changed_count_o = total_q;
  assign low_changed_o   = low_out_q;
  assign high_changed_o  = high_out_q;

endmodule

>>> src/frame_change_pixel_counter.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter
// Counts changed pixel pairs per frame and reports the counts at frame end.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock while in_stall_o is low. A pair
// is registered at the input, classified by short logic and counted when it
// leaves that register. The frame report is registered at that same edge, so
// out_valid_o rises as the frame's last pair leaves the input register. Input
// stall rises only when the last pair of a frame waits behind a report that
// the downstream side has not yet taken; all other pairs flow without pause.
module frame_change_pixel_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcpc_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fcpc_pkg::PIX_W-1:0]     prev_pixel_i,
  input  logic [fcpc_pkg::PIX_W-1:0]     curr_pixel_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           over_limit_o,
  output logic [fcpc_pkg::CNT_W-1:0]     changed_count_o,
  output logic [fcpc_pkg::CNT_W-1:0]     low_changed_o,
  output logic [fcpc_pkg::CNT_W-1:0]     high_changed_o
);
  import fcpc_pkg::*;

  cfg_t             cfg;
  pix_res_t         res;
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] prev_q, curr_q;
  logic             last_q;
  logic             slot_free;
  logic             adv;
  logic             accept;

  fcpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_comb begin
    adv        = s1_valid_q && (!last_q || slot_free);
    in_stall_o = s1_valid_q && !adv;
    accept     = in_valid_i && !in_stall_o;
    s1_valid_d = accept || (s1_valid_q && !adv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q <= prev_pixel_i;
      curr_q <= curr_pixel_i;
      last_q <= last_pixel_i;
    end
  end

  fcpc_classify u_classify (
    .prev_pixel_i (prev_q),
    .curr_pixel_i (curr_q),
    .last_pixel_i (last_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  fcpc_count u_count (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .res_i           (res),
    .area_limit_i    (cfg.area_limit),
    .slot_free_o     (slot_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .over_limit_o    (over_limit_o),
    .changed_count_o (changed_count_o),
    .low_changed_o   (low_changed_o),
    .high_changed_o  (high_changed_o)
  );

endmodule

>>> src/fcpc_checker.sv
// ----------------------------------------------------------------------------
// Frame change pixel counter checker
// Port-level checks on the report channel and the input stall.
// ----------------------------------------------------------------------------
module fcpc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       over_limit_o,
  input logic [fcpc_pkg::CNT_W-1:0] changed_count_o,
  input logic [fcpc_pkg::CNT_W-1:0] low_changed_o,
  input logic [fcpc_pkg::CNT_W-1:0] high_changed_o
);
  import fcpc_pkg::*;

  logic [CNT_W:0] sum;
  assign sum = {1'b0, low_changed_o} + {1'b0, high_changed_o};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("report dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(changed_count_o) && $stable(low_changed_o) &&
      $stable(high_changed_o) && $stable(over_limit_o))
    else $error("stalled report changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((sum > {1'b0, CNT_CAP}) ? (changed_count_o == CNT_CAP)
                               : (changed_count_o == sum[CNT_W-1:0])))
    else $error("total does not match its parts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty report slot");

endmodule

bind frame_change_pixel_counter fcpc_checker u_fcpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .over_limit_o    (over_limit_o),
  .changed_count_o (changed_count_o),
  .low_changed_o   (low_changed_o),
  .high_changed_o  (high_changed_o)
);
